// ----- src/vgaac_pkg.sv -----
// ----------------------------------------------------------------------------
// vgaac_pkg
// Shared types and constants of the vga attribute controller.
// ----------------------------------------------------------------------------
`default_nettype none

package vgaac_pkg;

  localparam int PALETTE_ENTRIES = 16;
  localparam int ENTRY_W         = $clog2(PALETTE_ENTRIES);
  localparam int PAL_W           = 6;

  // bus access kinds
  localparam logic [1:0] KIND_READ_INDEX = 2'd0;
  localparam logic [1:0] KIND_READ_DATA  = 2'd1;
  localparam logic [1:0] KIND_WRITE      = 2'd2;

  // register indexes behind the data port
  localparam logic [4:0] IDX_MODE     = 5'h10;
  localparam logic [4:0] IDX_OVERSCAN = 5'h11;
  localparam logic [4:0] IDX_PLANE    = 5'h12;
  localparam logic [4:0] IDX_PANNING  = 5'h13;
  localparam logic [4:0] IDX_COLSEL   = 5'h14;

  // configuration register indexes
  localparam logic CFG_IS_VGA       = 1'b0;
  localparam logic CFG_DISPLAY_MODE = 1'b1;

  // display modes
  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_256COL = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic               map_valid;
    logic [ENTRY_W-1:0] map_entry;
    logic [7:0]         map_value;
    logic [3:0]         effective_panning;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_MAP,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic               latch;
    logic               exec;
    logic               plain_emit;
    logic               read_emit;
    logic               map_issue;
    logic [ENTRY_W-1:0] map_entry;
    logic               map_last;
  } cmd_t;

  typedef struct packed {
    logic               all;
    logic               single;
    logic               need_read;
    logic [ENTRY_W-1:0] index;
  } status_t;

endpackage

`default_nettype wire

// ----- src/vgaac_ram.sv -----
// ----------------------------------------------------------------------------
// vgaac_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vgaac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/vgaac_ctrl.sv -----
// ----------------------------------------------------------------------------
// vgaac_ctrl
// Sequencer: accepts a bus access, runs it, then a palette read or a walk of palette mappings where needed.
// ----------------------------------------------------------------------------
`default_nettype none

module vgaac_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire vgaac_pkg::status_t  status,
  output logic                     busy,
  output vgaac_pkg::cmd_t          cmd
);

  vgaac_pkg::state_t                   state, state_next;
  logic [vgaac_pkg::ENTRY_W-1:0]       cnt;
  logic                                single_q;
  logic                                map_last;

  assign map_last = single_q || (cnt == vgaac_pkg::ENTRY_W'(vgaac_pkg::PALETTE_ENTRIES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      vgaac_pkg::ST_IDLE: begin
        if (start) state_next = vgaac_pkg::ST_EXEC;
      end
      vgaac_pkg::ST_EXEC: begin
        if (status.all || status.single) state_next = vgaac_pkg::ST_MAP;
        else if (status.need_read)       state_next = vgaac_pkg::ST_READ;
        else                             state_next = vgaac_pkg::ST_IDLE;
      end
      vgaac_pkg::ST_READ:  state_next = vgaac_pkg::ST_IDLE;
      vgaac_pkg::ST_MAP: begin
        if (map_last) state_next = vgaac_pkg::ST_DRAIN;
      end
      vgaac_pkg::ST_DRAIN: state_next = vgaac_pkg::ST_IDLE;
      default:             state_next = vgaac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.map_entry  = cnt;
    cmd.map_last   = map_last;
    busy           = (state != vgaac_pkg::ST_IDLE);
    unique case (state)
      vgaac_pkg::ST_IDLE:  cmd.latch = start;
      vgaac_pkg::ST_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.plain_emit = !status.all && !status.single && !status.need_read;
      end
      vgaac_pkg::ST_READ:  cmd.read_emit = 1'b1;
      vgaac_pkg::ST_MAP:   cmd.map_issue = 1'b1;
      vgaac_pkg::ST_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vgaac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == vgaac_pkg::ST_EXEC) begin
      cnt      <= status.all ? '0 : status.index;
      single_q <= !status.all;
    end else if (state == vgaac_pkg::ST_MAP) begin
      cnt <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- src/vgaac_datapath.sv -----
// ----------------------------------------------------------------------------
// vgaac_datapath
// Attribute registers, palette store and result formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module vgaac_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vgaac_pkg::item_t    item,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [1:0]          cfg_data,
  input  wire vgaac_pkg::cmd_t     cmd,
  output vgaac_pkg::status_t       status,
  output logic                     strobe,
  output vgaac_pkg::result_t       result
);

  localparam int EW = vgaac_pkg::ENTRY_W;
  localparam int PW = vgaac_pkg::PAL_W;

  logic             is_vga;
  logic [1:0]       display_mode;
  logic [1:0]       kind_q;
  logic [7:0]       data_q;
  logic [4:0]       index_register;
  logic             data_phase_flag;
  logic             palette_access_bit;
  logic [7:0]       mode_control_reg;
  logic [7:0]       overscan_reg;
  logic [7:0]       plane_enable_reg;
  logic [3:0]       panning_reg;
  logic [7:0]       colour_select_reg;
  logic [3:0]       panning_effective, panning_next;
  logic [vgaac_pkg::PALETTE_ENTRIES-1:0] pal_valid;

  logic             is_data_write;
  logic             pal_we;
  logic [7:0]       mode_new;
  logic [7:0]       mode_change;
  logic [7:0]       plain_rd;
  logic [EW-1:0]    raddr;
  logic [PW-1:0]    ram_q;
  logic             rd_valid_q;
  logic             issue_q;
  logic [EW-1:0]    entry_q;
  logic             last_q;
  logic [PW-1:0]    pal_val;
  logic [7:0]       map_val;

  function automatic logic [3:0] text_pan(input logic [3:0] p, input logic plus_one);
    if (p[3])       return 4'd0;
    else if (plus_one) return p + 4'd1;
    else            return p;
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      is_vga       <= 1'b1;
      display_mode <= vgaac_pkg::MODE_TEXT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vgaac_pkg::CFG_IS_VGA:       is_vga       <= cfg_data[0];
        vgaac_pkg::CFG_DISPLAY_MODE: display_mode <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q <= item.kind;
      data_q <= item.write_data;
    end
  end

  assign is_data_write = (kind_q == vgaac_pkg::KIND_WRITE) && data_phase_flag;
  assign mode_new      = is_vga ? data_q : (data_q & 8'h1F);
  assign mode_change   = mode_control_reg ^ mode_new;

  always_comb begin
    status           = '0;
    status.single    = is_data_write && !index_register[4] && palette_access_bit;
    status.need_read = (kind_q == vgaac_pkg::KIND_READ_DATA) && !index_register[4];
    status.index     = index_register[EW-1:0];
    if (is_data_write) begin
      unique case (index_register)
        vgaac_pkg::IDX_MODE:   status.all = mode_change[7];
        vgaac_pkg::IDX_PLANE:  status.all = (plane_enable_reg[3:0] != data_q[3:0]);
        vgaac_pkg::IDX_COLSEL: status.all = is_vga && (colour_select_reg != data_q);
        default:               status.all = 1'b0;
      endcase
    end
  end

  assign pal_we = cmd.exec && status.single;

  // read value for accesses that need no palette read
  always_comb begin
    plain_rd = 8'd0;
    if (kind_q == vgaac_pkg::KIND_READ_INDEX) begin
      plain_rd = {2'b00, !palette_access_bit, index_register};
    end else if (kind_q == vgaac_pkg::KIND_READ_DATA) begin
      unique case (index_register)
        vgaac_pkg::IDX_MODE:     plain_rd = mode_control_reg;
        vgaac_pkg::IDX_OVERSCAN: plain_rd = overscan_reg;
        vgaac_pkg::IDX_PLANE:    plain_rd = plane_enable_reg;
        vgaac_pkg::IDX_PANNING:  plain_rd = {4'd0, panning_reg};
        vgaac_pkg::IDX_COLSEL:   plain_rd = colour_select_reg;
        default:                 plain_rd = 8'd0;
      endcase
    end
  end

  always_comb begin
    panning_next = panning_effective;
    if (is_data_write && index_register == vgaac_pkg::IDX_MODE) begin
      if (mode_change[2] && display_mode == vgaac_pkg::MODE_TEXT) begin
        panning_next = text_pan(panning_reg, mode_new[2]);
      end
    end else if (is_data_write && index_register == vgaac_pkg::IDX_PANNING) begin
      priority if (display_mode == vgaac_pkg::MODE_TEXT) begin
        panning_next = text_pan(data_q[3:0], mode_control_reg[2]);
      end else if (display_mode == vgaac_pkg::MODE_256COL) begin
        panning_next = {2'b00, data_q[2:1]};
      end else begin
        panning_next = {1'b0, data_q[2:0]};
      end
    end
  end

  // register update
  always_ff @(posedge clk) begin
    if (rst) begin
      index_register     <= '0;
      data_phase_flag    <= 1'b0;
      palette_access_bit <= 1'b0;
      mode_control_reg   <= '0;
      overscan_reg       <= '0;
      plane_enable_reg   <= '0;
      panning_reg        <= '0;
      colour_select_reg  <= '0;
      panning_effective  <= '0;
      pal_valid          <= '0;
    end else if (cmd.exec) begin
      panning_effective <= panning_next;
      if (pal_we) pal_valid[index_register[EW-1:0]] <= 1'b1;
      if (kind_q == vgaac_pkg::KIND_WRITE) begin
        if (!data_phase_flag) begin
          index_register     <= data_q[4:0];
          data_phase_flag    <= 1'b1;
          palette_access_bit <= !data_q[5];
        end else begin
          data_phase_flag <= 1'b0;
          unique case (index_register)
            vgaac_pkg::IDX_MODE:     mode_control_reg <= mode_new;
            vgaac_pkg::IDX_OVERSCAN: overscan_reg     <= data_q;
            vgaac_pkg::IDX_PLANE:    plane_enable_reg <= data_q;
            vgaac_pkg::IDX_PANNING:  panning_reg      <= data_q[3:0];
            vgaac_pkg::IDX_COLSEL:   colour_select_reg <= is_vga ? data_q : 8'd0;
            default: ;
          endcase
        end
      end
    end
  end

  // palette store, one read port shared by data reads and mapping walks
  assign raddr = cmd.map_issue ? (cmd.map_entry & plane_enable_reg[EW-1:0])
                               : index_register[EW-1:0];

  vgaac_ram #(
    .WIDTH(PW),
    .DEPTH(vgaac_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (index_register[EW-1:0]),
    .wdata (data_q[PW-1:0]),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    rd_valid_q <= pal_valid[raddr];
    entry_q    <= cmd.map_entry;
    last_q     <= cmd.map_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_q <= 1'b0;
    end else begin
      issue_q <= cmd.map_issue;
    end
  end

  assign pal_val = rd_valid_q ? ram_q : '0;

  always_comb begin
    map_val = {{(8 - PW){1'b0}}, pal_val};
    if (mode_control_reg[7]) map_val = {colour_select_reg[3:0], pal_val[3:0]};
    map_val = map_val | {colour_select_reg[3:2], 6'd0};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.plain_emit || cmd.read_emit || issue_q;
    end
  end

  // a plain result leaves with the panning value that its own update sets
  always_ff @(posedge clk) begin
    if (cmd.plain_emit) begin
      result.read_data         <= plain_rd;
      result.map_valid         <= 1'b0;
      result.map_entry         <= '0;
      result.map_value         <= '0;
      result.effective_panning <= panning_next;
      result.last              <= 1'b1;
    end else if (cmd.read_emit) begin
      result.read_data         <= {{(8 - PW){1'b0}}, pal_val};
      result.map_valid         <= 1'b0;
      result.map_entry         <= '0;
      result.map_value         <= '0;
      result.effective_panning <= panning_effective;
      result.last              <= 1'b1;
    end else if (issue_q) begin
      result.read_data         <= '0;
      result.map_valid         <= 1'b1;
      result.map_entry         <= entry_q;
      result.map_value         <= map_val;
      result.effective_panning <= panning_effective;
      result.last              <= last_q;
    end
  end

endmodule

`default_nettype wire

// ----- src/vga_attribute_controller.sv -----
// ----------------------------------------------------------------------------
// vga_attribute_controller
// Attribute controller register block with palette-to-dac mapping reports.
// ----------------------------------------------------------------------------
// order: a plain access result is registered after the EXEC state, a palette
//   data read after READ and the palette ram, mappings after MAP and the ram
// busy: no new access is taken until the last one is done; a full remap walks
//   one palette entry per cycle
// reset: synchronous rst clears the attribute registers and palette valid bits
//   and sets vga text mode; results are strobed, the receiver cannot stall them
// ----------------------------------------------------------------------------
`default_nettype none

module vga_attribute_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  // command transaction
  input  wire logic                start,
  input  wire vgaac_pkg::item_t    item,
  output logic                     busy,
  // result transaction, one cycle per strobe
  output logic                     strobe,
  output vgaac_pkg::result_t       result,
  // configuration writes
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [1:0]          cfg_data
);

  // controller and datapath talk only over these
  vgaac_pkg::cmd_t    cmd;
  vgaac_pkg::status_t status;

  // sequencer: idle, run the access, optional palette read or mapping walk
  vgaac_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // registers, palette ram and result formatting
  vgaac_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for vga_attribute_controller
// Drives bus accesses through the start/busy command port and predicts every
// strobed result with a shadow copy of the attribute registers and palette.
// Runs a short directed pass, then random traffic under four register
// settings with varying gaps on the command side.
// ----------------------------------------------------------------------------

import vgaac_pkg::*;

class attr_ctrl_shadow;
  bit        is_vga;
  bit [1:0]  disp_mode;
  bit [5:0]  palette [PALETTE_ENTRIES];
  bit [4:0]  index_reg;
  bit        data_phase;
  bit        access_open;
  bit [7:0]  mode_ctl;
  bit [7:0]  overscan;
  bit [7:0]  plane_en;
  bit [7:0]  col_sel;
  bit [3:0]  pan_reg;
  bit [3:0]  pan_eff;
  result_t   pending_reports[$];
  int        mismatches;
  int        accesses;
  int        maps_seen;
  int        remaps;

  function new();
    is_vga    = 1'b1;
    disp_mode = MODE_TEXT;
  endfunction

  function void set_cfg(logic sel, logic [1:0] val);
    if (sel == CFG_IS_VGA) begin
      is_vga = val[0];
    end else begin
      disp_mode = val;
    end
  endfunction

  // dac index of one entry after plane masking and colour select substitution
  function logic [7:0] dac_index(logic [3:0] entry);
    logic [7:0] v;
    v = {2'b00, palette[entry & plane_en[3:0]]};
    if (mode_ctl[7]) begin
      v = {col_sel[3:0], v[3:0]};
    end
    v = v | {col_sel[3:2], 6'b000000};
    return v;
  endfunction

  function void text_pan();
    if (pan_reg > 4'd7) begin
      pan_eff = 4'd0;
    end else if (mode_ctl[2]) begin
      pan_eff = pan_reg + 4'd1;
    end else begin
      pan_eff = pan_reg;
    end
  endfunction

  function void push(logic [7:0] rd, logic valid, logic [3:0] entry, logic [7:0] value,
                     logic last);
    result_t r;
    r.read_data         = rd;
    r.map_valid         = valid;
    r.map_entry         = entry;
    r.map_value         = value;
    r.effective_panning = pan_eff;
    r.last              = last;
    pending_reports.push_back(r);
  endfunction

  // note one accepted transaction and queue the results it causes
  function void apply_access(item_t it);
    logic [7:0] rd;
    logic [7:0] d;
    logic [7:0] nv;
    logic [7:0] changed;
    logic       remap;
    logic       one_map;
    logic [3:0] one;
    rd      = 8'h00;
    d       = it.write_data;
    remap   = 1'b0;
    one_map = 1'b0;
    one     = 4'd0;
    accesses++;
    case (it.kind)
      KIND_READ_INDEX: begin
        rd = {2'b00, !access_open, index_reg};
      end
      KIND_READ_DATA: begin
        if (index_reg < 5'd16) begin
          rd = {2'b00, palette[index_reg[3:0]]};
        end else begin
          case (index_reg)
            IDX_MODE:     rd = mode_ctl;
            IDX_OVERSCAN: rd = overscan;
            IDX_PLANE:    rd = plane_en;
            IDX_PANNING:  rd = {4'h0, pan_reg};
            IDX_COLSEL:   rd = col_sel;
            default:      rd = 8'h00;
          endcase
        end
      end
      KIND_WRITE: begin
        if (!data_phase) begin
          index_reg   = d[4:0];
          data_phase  = 1'b1;
          access_open = !d[5];
        end else begin
          data_phase = 1'b0;
          if (index_reg < 5'd16) begin
            if (access_open) begin
              palette[index_reg[3:0]] = d[5:0];
              one_map = 1'b1;
              one     = index_reg[3:0];
            end
          end else begin
            case (index_reg)
              IDX_MODE: begin
                nv       = is_vga ? d : (d & 8'h1F);
                changed  = mode_ctl ^ nv;
                mode_ctl = nv;
                remap    = changed[7];
                if (changed[2] && disp_mode == MODE_TEXT) begin
                  text_pan();
                end
              end
              IDX_OVERSCAN: overscan = d;
              IDX_PLANE: begin
                remap    = (plane_en[3:0] != d[3:0]);
                plane_en = d;
              end
              IDX_PANNING: begin
                pan_reg = d[3:0];
                if (disp_mode == MODE_TEXT) begin
                  text_pan();
                end else if (disp_mode == MODE_256COL) begin
                  pan_eff = {1'b0, d[2:0]} >> 1;
                end else begin
                  pan_eff = {1'b0, d[2:0]};
                end
              end
              IDX_COLSEL: begin
                if (!is_vga) begin
                  col_sel = 8'h00;
                end else if (col_sel != d) begin
                  col_sel = d;
                  remap   = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    if (remap) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        push(8'h00, 1'b1, i[3:0], dac_index(i[3:0]), i == PALETTE_ENTRIES - 1);
      end
      remaps++;
      maps_seen += PALETTE_ENTRIES;
    end else if (one_map) begin
      push(8'h00, 1'b1, one, dac_index(one), 1'b1);
      maps_seen++;
    end else begin
      push(rd, 1'b0, 4'd0, 8'h00, 1'b1);
    end
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  task check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // compare one strobed result against the oldest prediction
  task compare_report(result_t got);
    result_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: %p", got));
      return;
    end
    want = pending_reports.pop_front();
    check_field("read_data", got.read_data, want.read_data);
    check_field("map_valid", 8'(got.map_valid), 8'(want.map_valid));
    check_field("map_entry", 8'(got.map_entry), 8'(want.map_entry));
    check_field("map_value", got.map_value, want.map_value);
    check_field("effective_panning", 8'(got.effective_panning),
                8'(want.effective_panning));
    check_field("last", 8'(got.last), 8'(want.last));
  endtask

  task flush_leftover();
    if (pending_reports.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                pending_reports.size()));
      pending_reports.delete();
    end
  endtask
endclass

module testbench;

  // kind 3 is not a real access, the block answers it like an empty read
  localparam logic [1:0] KIND_NONE      = 2'd3;
  localparam logic [1:0] MODE_OTHER     = 2'd2;
  localparam logic [1:0] MODE_RESERVED  = 2'd3;
  // index byte bit 5: set means the palette is locked against writes
  localparam logic [7:0] PAL_LOCK       = 8'h20;
  localparam logic [4:0] IDX_UNUSED_TOP = 5'h1F;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    start     = 1'b0;
  item_t   item      = '0;
  logic    busy;
  logic    strobe;
  result_t result;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [1:0] cfg_data  = 2'b00;

  attr_ctrl_shadow shadow = new();

  int sent         = 0;   // accepted transactions so far
  bit ff_data      = 1'b0; // where the index/data flip-flop stands, from our side
  int idle_pct     = 0;   // chance per cycle that the sender holds back
  int settings_run = 0;

  vga_attribute_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .strobe    (strobe),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor: everything is sampled at the rising edge, before any update
  // made at that edge lands, so results never depend on process order
  always @(posedge clk) begin
    if (!rst) begin
      // a result strobe is always for an older transaction, so check first
      if (strobe) begin
        shadow.compare_report(result);
      end
      if (start && !busy) begin
        shadow.apply_access(item);
      end
      if (cfg_write) begin
        shadow.set_cfg(cfg_index, cfg_data);
      end
    end
  end

  // offer one transaction and hold it until the block takes it; start is
  // left high afterwards so back-to-back transactions never drop it
  task automatic send_access(input logic [1:0] kind, input logic [7:0] data);
    item_t it;
    it.kind       = kind;
    it.write_data = data;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    sent++;
    if (kind == KIND_WRITE) begin
      ff_data = !ff_data;
    end
  endtask

  // index write followed by data write
  task automatic reg_write(input logic [7:0] sel, input logic [7:0] val);
    send_access(KIND_WRITE, sel);
    send_access(KIND_WRITE, val);
  endtask

  // both configuration registers, on back-to-back edges; the spare data bit
  // of the one-bit register gets a random value
  task automatic set_config(input logic vga, input logic [1:0] mode);
    cfg_write <= 1'b1;
    cfg_index <= CFG_IS_VGA;
    cfg_data  <= {1'($urandom_range(0, 1)), vga};
    @(posedge clk);
    cfg_index <= CFG_DISPLAY_MODE;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  // let every predicted result come back, then a few quiet cycles since a
  // mapping walk may still be winding down; the wait is bounded
  task automatic settle(input int tail);
    int waited;
    waited = 0;
    start <= 1'b0;
    while (shadow.pending_reports.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (tail) @(posedge clk);
    shadow.flush_leftover();
  endtask

  // index byte: mostly palette entries and the five registers, a few unused
  // indexes; the lock bit is set now and then, the top bits are noise
  function automatic logic [7:0] pick_selector();
    int         r;
    logic [4:0] ix;
    logic       lock;
    r    = $urandom_range(0, 99);
    lock = ($urandom_range(0, 99) < 15);
    if (r < 50) begin
      ix = 5'($urandom_range(0, 15));
    end else if (r < 90) begin
      ix = IDX_MODE + 5'($urandom_range(0, 4));
    end else begin
      ix = 5'($urandom_range(21, 31));
    end
    return {2'($urandom_range(0, 3)), lock, ix};
  endfunction

  task automatic random_traffic(input int n_items);
    int first;
    int pick;
    first = sent;
    while (sent - first < n_items) begin
      pick = $urandom_range(0, 99);
      // a well-formed sequence starts with the flip-flop on the index side
      if (pick < 75 && ff_data) begin
        send_access(KIND_WRITE, 8'($urandom_range(0, 255)));
      end
      if (pick < 60) begin
        reg_write(pick_selector(), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
          send_access(KIND_READ_DATA, 8'($urandom_range(0, 255)));
        end
      end else if (pick < 75) begin
        send_access(KIND_WRITE, pick_selector());
        send_access(KIND_READ_INDEX, 8'($urandom_range(0, 255)));
        send_access(KIND_READ_DATA, 8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        send_access(pick[0] ? KIND_READ_INDEX : KIND_READ_DATA, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        send_access(KIND_NONE, 8'($urandom_range(0, 255)));
      end else begin
        // lone write, knocks the flip-flop out of step
        send_access(KIND_WRITE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: vga, text mode, sender idles about a third of the time
    idle_pct = 37;
    set_config(1'b1, MODE_TEXT);

    // directed: reads straight out of reset show the lock bit set
    send_access(KIND_READ_INDEX, 8'h00);
    send_access(KIND_READ_DATA, 8'hFF);
    // full-scale palette write, only six bits are kept
    reg_write(8'h00, 8'hFF);
    // write to a locked palette is dropped, then read back the index
    reg_write(PAL_LOCK | 8'h0F, 8'h15);
    send_access(KIND_READ_INDEX, 8'h00);
    // plane enable low nibble change remaps every entry
    reg_write({3'b000, IDX_PLANE}, 8'hFF);
    reg_write(8'h0F, 8'hC0);
    // mode bit 7 flips, and bit 2 moves text panning
    reg_write({3'b000, IDX_MODE}, 8'hFF);
    // panning above 7 gives zero in text mode, 7 plus the bit 2 step gives 8
    reg_write({3'b000, IDX_PANNING}, 8'h0F);
    reg_write({3'b000, IDX_PANNING}, 8'h07);
    // colour select change remaps, the same value again does not
    reg_write({3'b000, IDX_COLSEL}, 8'hFF);
    reg_write({3'b000, IDX_COLSEL}, 8'hFF);
    // unknown index: write ignored, read gives zero
    reg_write({3'b111, IDX_UNUSED_TOP}, 8'h00);
    send_access(KIND_READ_DATA, 8'h00);
    send_access(KIND_NONE, 8'hFF);

    random_traffic(64);
    settle(8);

    // phase 2: ega with 256-colour panning, sender idles most of the time
    idle_pct = 62;
    set_config(1'b0, MODE_256COL);
    random_traffic(64);
    settle(8);

    // phase 3 and 4: no idling, other-mode panning and the reserved code
    idle_pct = 0;
    set_config(1'b1, MODE_OTHER);
    random_traffic(64);
    settle(8);
    set_config(1'b0, MODE_RESERVED);
    random_traffic(64);
    settle(8);

    $display("ran %0d bus transactions under %0d register settings",
             shadow.accesses, settings_run);
    $display("checked %0d palette mapping reports, %0d full remaps among them",
             shadow.maps_seen, shadow.remaps);
    if (shadow.mismatches == 0) begin
      $display("vga_attribute_controller regression: pass");
    end else begin
      $display("vga_attribute_controller regression: fail");
    end
    $finish;
  end

  // generous ceiling: about 300 transactions, each at worst a long sender gap
  // plus a full remap, stay well under a tenth of this
  initial begin
    #2_000_000;
    $display("vga_attribute_controller regression: fail");
    $finish;
  end

endmodule

// ----- vga_attribute_controller.f -----
src/vgaac_pkg.sv
src/vgaac_ram.sv
src/vgaac_ctrl.sv
src/vgaac_datapath.sv
src/vga_attribute_controller.sv
test/testbench.sv
